@@ rtl/multi_rate_capture_trigger_macros.svh @@
// assertion macros for the capture trigger checker
`ifndef MULTI_RATE_CAPTURE_TRIGGER_MACROS_SVH
`define MULTI_RATE_CAPTURE_TRIGGER_MACROS_SVH

// same-cycle implication, disabled in reset
`define MRCT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("capture trigger check failed");

// next-cycle implication, disabled in reset
`define MRCT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("capture trigger check failed");

`endif

@@ rtl/mrct_pkg.sv @@
// types and constants shared by the capture trigger modules
package mrct_pkg;

  localparam int unsigned SEQ_W       = 64;
  localparam int unsigned TIME_W      = 64;
  localparam int unsigned IV_W        = 34;
  localparam int unsigned CNT_W       = 3;
  localparam int unsigned IDX_W       = 2;
  localparam int unsigned REG_SENSORS = 4;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 34;

  localparam logic [CFG_IDX_W-1:0] REG_SENSOR_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL_0   = 3'd1;

  localparam logic [IV_W-1:0] INTERVAL_RESET = 34'd33333333;

  typedef struct packed {
    logic [SEQ_W-1:0]  seq_number;
    logic [TIME_W-1:0] sim_time_ns;
    logic              map_tag_present;
    logic              session_tag_present;
  } mrct_in_t;

  typedef struct packed {
    logic [IDX_W-1:0]  sensor_index;
    logic [SEQ_W-1:0]  source_seq;
    logic [TIME_W-1:0] capture_time_ns;
    logic              last_of_run;
  } mrct_out_t;

  typedef struct packed {
    logic                   load;
    logic [REG_SENSORS-1:0] mask;
  } mrct_emit_ctrl_t;

  typedef struct packed {
    logic empty;
  } mrct_emit_stat_t;

endpackage

@@ rtl/mrct_sub.sv @@
// shared 64-bit subtractor with borrow, used for every compare of the walk
module mrct_sub (
  input  logic [mrct_pkg::TIME_W-1:0] a_i,
  input  logic [mrct_pkg::TIME_W-1:0] b_i,
  output logic [mrct_pkg::TIME_W-1:0] diff_o,
  output logic                        borrow_o
);
  import mrct_pkg::*;

  logic [TIME_W:0] res;

  assign res      = {1'b0, a_i} - {1'b0, b_i};
  assign diff_o   = res[TIME_W-1:0];
  assign borrow_o = res[TIME_W];

endmodule

@@ rtl/mrct_emit.sv @@
// result output register, drains the fire mask one beat at a time
module mrct_emit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mrct_pkg::mrct_emit_ctrl_t     ctrl_i,
  output mrct_pkg::mrct_emit_stat_t     stat_o,
  input  logic [mrct_pkg::SEQ_W-1:0]    seq_i,
  input  logic [mrct_pkg::TIME_W-1:0]   time_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output mrct_pkg::mrct_out_t           out_data_o
);
  import mrct_pkg::*;

  logic [REG_SENSORS-1:0] mask_q, mask_d;
  logic                   valid_q, valid_d;
  mrct_out_t              out_q, out_d;
  logic [IDX_W-1:0]       sel;
  logic [REG_SENSORS-1:0] rest;
  logic                   take;

  always_comb begin
    sel = '0;
    for (int i = REG_SENSORS - 1; i >= 0; i--) begin
      if (mask_q[i]) begin
        sel = IDX_W'(i);
      end
    end
  end

  assign rest = mask_q & ~(REG_SENSORS'(1) << sel);
  assign take = !valid_q || !out_stall_i;

  always_comb begin
    mask_d  = mask_q;
    valid_d = valid_q;
    out_d   = out_q;
    if (ctrl_i.load) begin
      mask_d = ctrl_i.mask;
      if (take) begin
        valid_d = 1'b0;
      end
    end else if (take && (mask_q != '0)) begin
      out_d.sensor_index    = sel;
      out_d.source_seq      = seq_i;
      out_d.capture_time_ns = time_i;
      out_d.last_of_run     = (rest == '0);
      valid_d               = 1'b1;
      mask_d                = rest;
    end else if (take) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      mask_q  <= mask_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign stat_o.empty = (mask_q == '0);
  assign out_valid_o  = valid_q;
  assign out_data_o   = out_q;

endmodule

@@ rtl/multi_rate_capture_trigger.sv @@
// capture trigger top level: config registers, sensor store and walk sequencer
//
// One state update comes in per input beat (in_valid_i / in_stall_o). in_stall_o
// is high from the cycle after an accepted beat until the update is fully
// processed. Each update is checked in the CHECK state; an accepted update then
// walks the active sensors on the one shared subtractor, per sensor a time
// difference (DIFF) then a compare with the interval (CMP). Firing sensors leave
// as result beats on out_valid_o / out_data_o, one per cycle while out_stall_i
// is low, lowest index first, with last_of_run on the final one. A rejected
// update gives no beat. An accepted one returns to idle after the walk when no
// sensor fires, otherwise once the EMIT state has handed every firing sensor to
// the output register. A stalled result beat holds in the output register; the
// next update is taken while the final beat waits. Config writes (cfg_we_i)
// must be made only while idle; the block itself does not enforce this. Writing
// the sensor count clears the last sequence and all capture times. Reset gives
// count 0, all intervals 33333333 ns, cleared state.
module multi_rate_capture_trigger #(
  parameter int unsigned MAX_SENSORS = 4
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  mrct_pkg::mrct_in_t                in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output mrct_pkg::mrct_out_t               out_data_o,
  input  logic                              cfg_we_i,
  input  logic [mrct_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [mrct_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import mrct_pkg::*;

  localparam int unsigned NS     = (MAX_SENSORS < REG_SENSORS) ? MAX_SENSORS : REG_SENSORS;
  localparam int unsigned SIDX_W = (NS > 1) ? $clog2(NS) : 1;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CHECK = 3'd1;
  localparam logic [2:0] ST_DIFF  = 3'd2;
  localparam logic [2:0] ST_CMP   = 3'd3;
  localparam logic [2:0] ST_EMIT  = 3'd4;

  logic [2:0]             state_q, state_d;
  mrct_in_t               item_q;
  logic [CNT_W-1:0]       count_q;
  logic [IV_W-1:0]        interval_q [NS];
  logic [SEQ_W-1:0]       last_seq_q;
  logic [TIME_W-1:0]      times_q [NS];
  logic [SIDX_W-1:0]      idx_q;
  logic [TIME_W-1:0]      diff_q;
  logic                   back_q;
  logic                   never_q;
  logic [REG_SENSORS-1:0] mask_q;

  logic [TIME_W-1:0]      op_a, op_b, sub_diff;
  logic                   sub_borrow;
  logic [CNT_W-1:0]       n_act;
  logic                   in_take;
  logic                   upd_ok;
  logic                   fire;
  logic                   last_sensor;
  logic [REG_SENSORS-1:0] mask_next;
  mrct_emit_ctrl_t        emit_ctrl;
  mrct_emit_stat_t        emit_stat;

  assign n_act   = (count_q > CNT_W'(NS)) ? CNT_W'(NS) : count_q;
  assign in_take = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    op_a = '0;
    op_b = '0;
    case (state_q)
      ST_CHECK: begin
        op_a = last_seq_q;
        op_b = item_q.seq_number;
      end
      ST_DIFF: begin
        op_a = item_q.sim_time_ns;
        op_b = times_q[idx_q];
      end
      ST_CMP: begin
        op_a = diff_q;
        op_b = TIME_W'(interval_q[idx_q]);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  mrct_sub u_sub (
    .a_i      (op_a),
    .b_i      (op_b),
    .diff_o   (sub_diff),
    .borrow_o (sub_borrow)
  );

  assign upd_ok = (n_act != '0) && (item_q.seq_number != '0) && sub_borrow &&
                  item_q.map_tag_present && item_q.session_tag_present;
  assign fire        = never_q || (!back_q && !sub_borrow);
  assign last_sensor = (CNT_W'(idx_q) == (n_act - CNT_W'(1)));

  always_comb begin
    mask_next = mask_q;
    if (fire) begin
      mask_next[idx_q] = 1'b1;
    end
  end

  always_comb begin
    state_d        = state_q;
    emit_ctrl.load = 1'b0;
    emit_ctrl.mask = mask_next;
    case (state_q)
      ST_IDLE: begin
        if (in_take) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_d = upd_ok ? ST_DIFF : ST_IDLE;
      end
      ST_DIFF: begin
        state_d = ST_CMP;
      end
      ST_CMP: begin
        if (last_sensor) begin
          if (mask_next != '0) begin
            emit_ctrl.load = 1'b1;
            state_d        = ST_EMIT;
          end else begin
            state_d = ST_IDLE;
          end
        end else begin
          state_d = ST_DIFF;
        end
      end
      ST_EMIT: begin
        if (emit_stat.empty) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      count_q    <= '0;
      last_seq_q <= '0;
      idx_q      <= '0;
      mask_q     <= '0;
      for (int i = 0; i < NS; i++) begin
        interval_q[i] <= INTERVAL_RESET;
        times_q[i]    <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        if (cfg_index_i == REG_SENSOR_COUNT) begin
          count_q    <= cfg_data_i[CNT_W-1:0];
          last_seq_q <= '0;
          for (int i = 0; i < NS; i++) begin
            times_q[i] <= '0;
          end
        end
        for (int i = 0; i < NS; i++) begin
          if (cfg_index_i == (REG_INTERVAL_0 + CFG_IDX_W'(i))) begin
            interval_q[i] <= cfg_data_i[IV_W-1:0];
          end
        end
      end
      if ((state_q == ST_CHECK) && upd_ok) begin
        last_seq_q <= item_q.seq_number;
        idx_q      <= '0;
        mask_q     <= '0;
      end
      if (state_q == ST_CMP) begin
        mask_q <= mask_next;
        if (fire) begin
          times_q[idx_q] <= item_q.sim_time_ns;
        end
        if (!last_sensor) begin
          idx_q <= idx_q + SIDX_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q <= in_data_i;
    end
    if (state_q == ST_DIFF) begin
      diff_q  <= sub_diff;
      back_q  <= sub_borrow;
      never_q <= (times_q[idx_q] == '0);
    end
  end

  mrct_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (emit_ctrl),
    .stat_o      (emit_stat),
    .seq_i       (item_q.seq_number),
    .time_i      (item_q.sim_time_ns),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

@@ rtl/mrct_checker.sv @@
// port-level checker for the capture trigger, bound to the top level
`include "multi_rate_capture_trigger_macros.svh"

module mrct_checker #(
  parameter int unsigned MAX_SENSORS = 4
) (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_stall_o,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input mrct_pkg::mrct_out_t               out_data_o
);
  import mrct_pkg::*;

  logic out_take;
  logic in_take;

  assign out_take = out_valid_o && !out_stall_i;
  assign in_take  = in_valid_i && !in_stall_o;

  `MRCT_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o))

  `MRCT_ASSERT_NEXT(a_busy_after_beat, in_take, in_stall_o)

  `MRCT_ASSERT_NOW(a_index_range, out_valid_o,
                   32'(out_data_o.sensor_index) < MAX_SENSORS)

  `MRCT_ASSERT_NEXT(a_run_order, out_take && !out_data_o.last_of_run,
                    !out_valid_o ||
                    ((out_data_o.sensor_index > $past(out_data_o.sensor_index)) &&
                     (out_data_o.source_seq == $past(out_data_o.source_seq))))

endmodule

bind multi_rate_capture_trigger mrct_checker #(.MAX_SENSORS(MAX_SENSORS)) u_mrct_checker (.*);
